// ----- src/efd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants for the escaped frame deframer.
// ----------------------------------------------------------------------------
package efd_pkg;

  // Field widths.
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 1;

  // Register reset values.
  localparam logic [ByteW-1:0] SyncReset = 8'hAA;
  localparam logic [ByteW-1:0] MaxPayloadReset = 8'hFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSyncValue = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxPayload = 1'b1;

  // Queue depth between the classifier and the deframer.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  // Frame parsing phase.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_CMD  = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  // One classified item waiting for the deframer.
  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             is_sync;
  } rx_entry_t;

endpackage

// ----- src/efd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_front
// Accepts received bytes, tags each against the sync value and holds them
// in a short queue until the deframer takes them.
// ----------------------------------------------------------------------------
module efd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [efd_pkg::ByteW-1:0] in_rx_byte,
  input  logic [efd_pkg::ByteW-1:0] sync_value,
  output logic                      q_valid,
  output efd_pkg::rx_entry_t        q_entry,
  input  logic                      q_pop
);

  efd_pkg::rx_entry_t                  mem_r [efd_pkg::QueueDepth];
  logic [efd_pkg::QueuePtrW-1:0]       wr_ptr_r;
  logic [efd_pkg::QueuePtrW-1:0]       rd_ptr_r;
  logic [efd_pkg::QueueCntW-1:0]       count_r;
  logic [efd_pkg::QueueCntW-1:0]       count_nxt;
  logic                                push;
  logic                                pop;
  efd_pkg::rx_entry_t                  new_entry;

  // Classify the incoming item.
  always_comb begin
    new_entry.rx_byte = in_rx_byte;
    new_entry.is_sync = (in_rx_byte == sync_value);
  end

  // Handshake with both sides of the queue.
  assign in_stall = (count_r == efd_pkg::QueueCntW'(efd_pkg::QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_entry  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

  // Occupancy never runs past the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= efd_pkg::QueueCntW'(efd_pkg::QueueDepth))
    else $error("queue occupancy beyond depth");

  // A full queue does not take another item.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == efd_pkg::QueueCntW'(efd_pkg::QueueDepth)) && !pop |=>
      (count_r == efd_pkg::QueueCntW'(efd_pkg::QueueDepth)))
    else $error("queue overrun");

  // An empty queue cannot be drained.
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |=> (count_r <= efd_pkg::QueueCntW'(1)))
    else $error("queue underrun");

endmodule

// ----- src/efd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_back
// Frame state machine: hunts for sync, takes command and length, destuffs
// the payload and loads results into the output register.
// ----------------------------------------------------------------------------
module efd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  efd_pkg::rx_entry_t        q_entry,
  output logic                      q_pop,
  input  logic [efd_pkg::ByteW-1:0] max_payload,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [efd_pkg::ByteW-1:0] out_command,
  output logic [efd_pkg::ByteW-1:0] out_data_byte,
  output logic                      out_data_valid,
  output logic [efd_pkg::ByteW-1:0] out_byte_index,
  output logic                      out_last,
  output logic                      out_too_long
);

  efd_pkg::phase_t             phase_r;
  efd_pkg::phase_t             phase_nxt;
  logic [efd_pkg::ByteW-1:0]   command_r;
  logic [efd_pkg::ByteW-1:0]   command_nxt;
  logic [efd_pkg::ByteW-1:0]   length_r;
  logic [efd_pkg::ByteW-1:0]   length_nxt;
  logic [efd_pkg::ByteW-1:0]   consumed_r;
  logic [efd_pkg::ByteW-1:0]   consumed_nxt;
  logic                        skip_r;
  logic                        skip_nxt;
  logic [efd_pkg::ByteW-1:0]   pcount_r;
  logic [efd_pkg::ByteW-1:0]   pcount_nxt;
  logic                        ovf_r;
  logic                        ovf_nxt;

  logic                        can_load;
  logic                        fire;
  logic                        res_valid;
  logic                        res_data_valid;
  logic                        res_last;

  logic                        out_valid_r;
  logic [efd_pkg::ByteW-1:0]   out_command_r;
  logic [efd_pkg::ByteW-1:0]   out_data_byte_r;
  logic                        out_data_valid_r;
  logic [efd_pkg::ByteW-1:0]   out_byte_index_r;
  logic                        out_last_r;
  logic                        out_too_long_r;

  // An item is taken when the output register can hold its result.
  assign can_load = !out_valid_r || !out_stall;
  assign fire     = q_valid && can_load;
  assign q_pop    = fire;

  // Frame counters and the end-of-frame test.
  always_comb begin
    command_nxt    = command_r;
    length_nxt     = length_r;
    consumed_nxt   = consumed_r;
    skip_nxt       = skip_r;
    pcount_nxt     = pcount_r;
    ovf_nxt        = ovf_r;
    res_data_valid = 1'b0;
    res_last       = 1'b0;
    unique case (phase_r)
      efd_pkg::PH_HUNT: begin
      end
      efd_pkg::PH_CMD: begin
        if (!q_entry.is_sync) begin
          command_nxt = q_entry.rx_byte;
        end
      end
      efd_pkg::PH_LEN: begin
        length_nxt   = q_entry.rx_byte;
        consumed_nxt = '0;
        skip_nxt     = 1'b0;
        pcount_nxt   = '0;
        ovf_nxt      = 1'b0;
        res_last     = (q_entry.rx_byte == '0);
      end
      efd_pkg::PH_DATA: begin
        consumed_nxt = consumed_r + 1'b1;
        if (skip_r) begin
          // Escape twin: dropped.
          skip_nxt = 1'b0;
        end else begin
          skip_nxt = q_entry.is_sync;
          if ((pcount_r < max_payload) && !ovf_r) begin
            res_data_valid = 1'b1;
            pcount_nxt     = pcount_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        res_last = (consumed_nxt == length_r);
        if (res_last) begin
          skip_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_valid = res_data_valid || res_last;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      efd_pkg::PH_HUNT: begin
        if (q_entry.is_sync) begin
          phase_nxt = efd_pkg::PH_CMD;
        end
      end
      efd_pkg::PH_CMD: begin
        phase_nxt = q_entry.is_sync ? efd_pkg::PH_HUNT : efd_pkg::PH_LEN;
      end
      efd_pkg::PH_LEN: begin
        phase_nxt = (q_entry.rx_byte == '0) ? efd_pkg::PH_HUNT : efd_pkg::PH_DATA;
      end
      efd_pkg::PH_DATA: begin
        if (res_last) begin
          phase_nxt = efd_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_nxt = efd_pkg::PH_HUNT;
      end
    endcase
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= efd_pkg::PH_HUNT;
      command_r  <= '0;
      length_r   <= '0;
      consumed_r <= '0;
      skip_r     <= 1'b0;
      pcount_r   <= '0;
      ovf_r      <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      command_r  <= command_nxt;
      length_r   <= length_nxt;
      consumed_r <= consumed_nxt;
      skip_r     <= skip_nxt;
      pcount_r   <= pcount_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_load) begin
      out_valid_r <= fire && res_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_command_r    <= command_r;
      out_data_byte_r  <= res_data_valid ? q_entry.rx_byte : '0;
      out_data_valid_r <= res_data_valid;
      out_byte_index_r <= res_data_valid ? pcount_r : '0;
      out_last_r       <= res_last;
      out_too_long_r   <= res_last && ovf_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_command    = out_command_r;
  assign out_data_byte  = out_data_byte_r;
  assign out_data_valid = out_data_valid_r;
  assign out_byte_index = out_byte_index_r;
  assign out_last       = out_last_r;
  assign out_too_long   = out_too_long_r;

  // The overflow flag only rides on the result that ends the frame.
  a_too_long_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_too_long_r |-> out_last_r)
    else $error("too_long without last");

  // A result with no payload byte must close the frame.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_valid_r |-> out_last_r)
    else $error("empty result that does not end the frame");

  // Without a payload byte the data and index fields read zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_valid_r |->
      (out_data_byte_r == '0) && (out_byte_index_r == '0))
    else $error("nonzero data on an empty result");

  // Payload indexes never reach the configured limit.
  a_index_limit: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_data_valid |-> (pcount_r < max_payload))
    else $error("payload byte emitted past the limit");

endmodule

// ----- src/escaped_frame_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_deframer
// Byte-stuffed frame deframer with a programmable sync byte and length limit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per item on in_rx_byte, qualified by
//   in_valid and held off by in_stall. Each byte is tagged against the sync
//   value and placed in a two-entry queue in front of the frame state machine.
//   Output channel: zero or one result per item, in out_valid/out_stall with
//   the command, destuffed byte, its index and the last/too_long flags.
//   Throughput is one item per clock while out_stall is low: the state machine
//   updates once per byte and the queue plus the output register keep both
//   sides moving. An accepted item waits in the queue; its result, if any, is
//   then loaded into the output register and marked by out_valid until it is
//   taken.
//   When the receiver stalls, the output register holds its result, the
//   state machine waits and the queue fills; in_stall rises when both queue
//   entries are taken.
//   Configuration: cfg_we with cfg_index selects sync_value (0) or
//   max_payload (1); writes belong in idle periods.
//   Reset (synchronous, rst_n low) empties the queue and output register,
//   returns to sync hunting, and loads sync 0xAA and a limit of 255 bytes.
// ----------------------------------------------------------------------------
module escaped_frame_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [efd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [efd_pkg::ByteW-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [efd_pkg::ByteW-1:0]   in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [efd_pkg::ByteW-1:0]   out_command,
  output logic [efd_pkg::ByteW-1:0]   out_data_byte,
  output logic                        out_data_valid,
  output logic [efd_pkg::ByteW-1:0]   out_byte_index,
  output logic                        out_last,
  output logic                        out_too_long
);

  logic [efd_pkg::ByteW-1:0] sync_value_r;
  logic [efd_pkg::ByteW-1:0] max_payload_r;
  logic                      q_valid;
  logic                      q_pop;
  efd_pkg::rx_entry_t        q_entry;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r  <= efd_pkg::SyncReset;
      max_payload_r <= efd_pkg::MaxPayloadReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        efd_pkg::CfgSyncValue:  sync_value_r  <= cfg_wdata;
        efd_pkg::CfgMaxPayload: max_payload_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Classifier and queue.
  efd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .sync_value (sync_value_r),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop)
  );

  // Frame state machine and output register.
  efd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .max_payload    (max_payload_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_command    (out_command),
    .out_data_byte  (out_data_byte),
    .out_data_valid (out_data_valid),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .out_too_long   (out_too_long)
  );

endmodule

// ----- test/escaped_frame_deframer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_deframer_tb
// Self-checking testbench for the escaped frame deframer. A scoreboard class
// tracks the frame parser's state and registers, predicts the result of every
// accepted byte and checks each result field by field. A short directed part
// covers the corner cases. Phases of random frames follow under several
// register settings, with random idling on both channels, a long receiver
// hold-off and drained pauses between the phases.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_tb;
  import efd_pkg::*;

  localparam int unsigned ClkPeriod = 10;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldOffCycles = 120;
  localparam int unsigned PhaseItems = 250;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned MaxReported = 10;

  // One result item as seen on the output channel.
  typedef struct packed {
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] data_byte;
    logic             data_valid;
    logic [ByteW-1:0] byte_index;
    logic             last;
    logic             too_long;
  } frame_result_t;

  // Tracks the frame parser and holds the results still owed by the block.
  class frame_scoreboard;
    logic [ByteW-1:0] sync_value;
    logic [ByteW-1:0] max_payload;
    phase_t           phase;
    logic [ByteW-1:0] frame_command;
    logic [ByteW-1:0] stuffed_length;
    logic [ByteW-1:0] consumed_count;
    logic [ByteW-1:0] payload_count;
    logic             skip_pending;
    logic             overflowed;
    frame_result_t    owed_results[$];
    int               mismatches;

    function new();
      sync_value     = SyncReset;
      max_payload    = MaxPayloadReset;
      phase          = PH_HUNT;
      frame_command  = '0;
      stuffed_length = '0;
      consumed_count = '0;
      payload_count  = '0;
      skip_pending   = 1'b0;
      overflowed     = 1'b0;
      mismatches     = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] index, logic [ByteW-1:0] value);
      case (index)
        CfgSyncValue: begin
          sync_value = value;
        end
        CfgMaxPayload: begin
          max_payload = value;
        end
        default: begin
        end
      endcase
    endfunction

    // Advances the parser by one accepted byte and queues the result it causes.
    function void deframe_byte(logic [ByteW-1:0] rx);
      frame_result_t res;
      logic          done;
      res = '0;
      case (phase)
        PH_HUNT: begin
          if (rx == sync_value) phase = PH_CMD;
        end
        PH_CMD: begin
          if (rx == sync_value) begin
            phase = PH_HUNT;
          end else begin
            frame_command = rx;
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          stuffed_length = rx;
          consumed_count = '0;
          skip_pending   = 1'b0;
          payload_count  = '0;
          overflowed     = 1'b0;
          if (rx == '0) begin
            // An empty frame ends on its length byte.
            phase = PH_HUNT;
            res.command = frame_command;
            res.last = 1'b1;
            owed_results.push_back(res);
          end else begin
            phase = PH_DATA;
          end
        end
        PH_DATA: begin
          consumed_count = consumed_count + 1'b1;
          if (skip_pending) begin
            // The twin of an escape byte is dropped.
            skip_pending = 1'b0;
          end else begin
            if (rx == sync_value) skip_pending = 1'b1;
            if (payload_count < max_payload && !overflowed) begin
              res.data_valid = 1'b1;
              res.data_byte  = rx;
              res.byte_index = payload_count;
              payload_count  = payload_count + 1'b1;
            end else begin
              overflowed = 1'b1;
            end
          end
          done = (consumed_count == stuffed_length);
          if (done) begin
            phase = PH_HUNT;
            skip_pending = 1'b0;
          end
          if (res.data_valid || done) begin
            res.command  = frame_command;
            res.last     = done;
            res.too_long = done && overflowed;
            owed_results.push_back(res);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function string describe(frame_result_t r);
      return $sformatf("cmd=%02h data=%02h dv=%0b idx=%0d last=%0b too_long=%0b",
                       r.command, r.data_byte, r.data_valid, r.byte_index, r.last,
                       r.too_long);
    endfunction

    // Compares an accepted result with the oldest owed one.
    function void check_result(frame_result_t got);
      frame_result_t want;
      string         diff;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("ERROR: result with none expected: %s", describe(got));
      end else begin
        want = owed_results.pop_front();
        diff = "";
        if (got.command !== want.command) diff = {diff, " command"};
        if (got.data_byte !== want.data_byte) diff = {diff, " data_byte"};
        if (got.data_valid !== want.data_valid) diff = {diff, " data_valid"};
        if (got.byte_index !== want.byte_index) diff = {diff, " byte_index"};
        if (got.last !== want.last) diff = {diff, " last"};
        if (got.too_long !== want.too_long) diff = {diff, " too_long"};
        if (diff != "") begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("ERROR: mismatch in%s", diff);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgSyncValue;
  logic [ByteW-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] in_rx_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ByteW-1:0] out_command;
  logic [ByteW-1:0] out_data_byte;
  logic             out_data_valid;
  logic [ByteW-1:0] out_byte_index;
  logic             out_last;
  logic             out_too_long;

  frame_scoreboard sb = new();

  bit fast_sender = 1'b0;
  bit fast_receiver = 1'b0;
  bit hold_off_req = 1'b0;
  int frame_items = 0;

  escaped_frame_deframer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_command    (out_command),
    .out_data_byte  (out_data_byte),
    .out_data_valid (out_data_valid),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .out_too_long   (out_too_long)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Offers one byte after a random gap and returns once it is accepted.
  task automatic send_byte(input logic [ByteW-1:0] value, input bit counted);
    int gap;
    gap = fast_sender ? 0 : $urandom_range(13, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.deframe_byte(value);
    if (counted) frame_items++;
  endtask

  // Stops offering items and waits until every owed result has arrived and
  // any trailing bytes without a result have passed through the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes the sync value, then the payload limit, with cfg_we held high for both writes.
  task automatic write_config(input logic [ByteW-1:0] sync, input logic [ByteW-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CfgSyncValue;
    cfg_wdata <= sync;
    @(posedge clk);
    sb.set_register(CfgSyncValue, sync);
    cfg_index <= CfgMaxPayload;
    cfg_wdata <= limit;
    @(posedge clk);
    sb.set_register(CfgMaxPayload, limit);
    cfg_we <= 1'b0;
  endtask

  // Sends one frame, mostly well formed, sometimes noisy or broken.
  task automatic send_frame();
    int               kind;
    int               sel;
    int               target;
    int               count;
    int               n;
    logic [ByteW-1:0] sync;
    logic [ByteW-1:0] rx;
    sync = sb.sync_value;
    kind = $urandom_range(99, 0);
    // Line noise that the hunt skips over.
    if (kind < 8)
      repeat ($urandom_range(5, 1)) send_byte(ByteW'($urandom_range(255, 0)), 1'b0);
    send_byte(sync, 1'b1);
    // A sync in the command position restarts the hunt.
    if (kind >= 8 && kind < 16) begin
      send_byte(sync, 1'b1);
    end else begin
      rx = ByteW'($urandom_range(255, 0));
      while (rx == sync) rx = ByteW'($urandom_range(255, 0));
      send_byte(rx, 1'b1);

      // Stuffed length: mostly short, a few long ones, some equal to sync.
      sel = $urandom_range(99, 0);
      if (sel < 6) target = 0;
      else if (sel < 12 && sync <= 40) target = int'(sync);
      else if (sel < 80) target = $urandom_range(12, 1);
      else if (sel < 97) target = $urandom_range(60, 13);
      else target = $urandom_range(255, 61);
      send_byte(target[ByteW-1:0], 1'b1);

      // Truncated frames let the next frame's bytes run into the payload.
      sel = $urandom_range(99, 0);
      if (sel < 6 && target > 0) count = $urandom_range(target - 1, 0);
      else count = target;
      n = 0;
      while (n < count) begin
        if ($urandom_range(3, 0) == 0) rx = sync;
        else rx = ByteW'($urandom_range(255, 0));
        send_byte(rx, 1'b1);
        n++;
        // An escape byte gets its twin unless it is the final stuffed byte.
        if (rx == sync && n < count) begin
          if ($urandom_range(3, 0) == 0) send_byte(ByteW'($urandom_range(255, 0)), 1'b1);
          else send_byte(sync, 1'b1);
          n++;
        end
      end
      // Trailing bytes past the frame end fall back into the hunt.
      if (sel >= 94)
        repeat ($urandom_range(4, 1)) send_byte(ByteW'($urandom_range(255, 0)), 1'b1);
    end
  endtask

  // Result side: random stall before each item, one long hold-off on request.
  initial begin : result_sink
    int            stall_cycles;
    frame_result_t got;
    forever begin
      if (hold_off_req) begin
        stall_cycles = HoldOffCycles;
        hold_off_req = 1'b0;
      end else begin
        stall_cycles = fast_receiver ? 0 : $urandom_range(13, 0);
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      // Only a definite high valid counts, so nothing is taken before reset.
      while (out_valid !== 1'b1) @(posedge clk);
      got.command    = out_command;
      got.data_byte  = out_data_byte;
      got.data_valid = out_data_valid;
      got.byte_index = out_byte_index;
      got.last       = out_last;
      got.too_long   = out_too_long;
      sb.check_result(got);
    end
  end

  // Ends the run when no item moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("ERROR: no item accepted for %0d cycles", WatchdogLimit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int               ph;
    int               phase_end;
    logic [ByteW-1:0] sync;
    logic [ByteW-1:0] limit;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Noise, a restarted hunt and an empty frame under the reset settings.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(SyncReset, 1'b1);
    send_byte(SyncReset, 1'b1);
    send_byte(SyncReset, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    // Escape with twin, then an escape as the final stuffed byte.
    send_byte(SyncReset, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h03, 1'b1);
    send_byte(SyncReset, 1'b1);
    send_byte(8'h11, 1'b1);
    send_byte(SyncReset, 1'b1);
    // Frame that ends on an escape twin, without data.
    send_byte(SyncReset, 1'b1);
    send_byte(8'h02, 1'b1);
    send_byte(8'h02, 1'b1);
    send_byte(SyncReset, 1'b1);
    send_byte(SyncReset, 1'b1);
    wait_drained();

    // Length equal to the sync value, and every payload byte over the limit.
    write_config(8'h02, 8'h00);
    send_byte(8'h02, 1'b1);
    send_byte(8'h10, 1'b1);
    send_byte(8'h02, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'h66, 1'b1);
    wait_drained();

    // Random phases, each under its own register setting and idling mix.
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin sync = 8'hAA; limit = 8'hFF; end
        1: begin sync = 8'h00; limit = 8'h00; end
        2: begin sync = 8'hFF; limit = 8'hFF; end
        3: begin sync = 8'h00; limit = 8'h05; end
        4: begin sync = 8'hFF; limit = 8'h01; end
        5: begin
          sync  = ByteW'($urandom_range(20, 1));
          limit = ByteW'($urandom_range(255, 0));
        end
        6: begin
          sync  = ByteW'($urandom_range(255, 0));
          limit = ByteW'($urandom_range(12, 0));
        end
        default: begin sync = 8'hAA; limit = ByteW'($urandom_range(255, 0)); end
      endcase
      write_config(sync, limit);
      fast_sender   = (ph == 1 || ph == 4 || ph == 5);
      fast_receiver = (ph == 1 || ph == 6);
      // The receiver holds off while the sender keeps pushing items.
      if (ph == 4) hold_off_req = 1'b1;
      phase_end = frame_items + PhaseItems;
      while (frame_items < phase_end) send_frame();
      wait_drained();
    end

    fast_sender = 1'b0;
    fast_receiver = 1'b0;
    if (sb.owed_results.size() != 0)
      $display("ERROR: %0d expected results never arrived", sb.owed_results.size());
    if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
